>>> sv/isru_pkg.sv
// isru_pkg: widths, fixed-point constants, register codes and divider structs
// for the iterative square root unit. depends on nothing.

package isru_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_WIDTH  = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_WIDTH);
    localparam int ITER_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ITER_W;

    localparam logic [DATA_WIDTH-1:0] ONE_FX =
        {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] DATA_MAX = {DATA_WIDTH{1'b1}};
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST = DIV_CNT_W'(DIV_WIDTH - 1);

    localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 1'b1;

    localparam logic              METHOD_NEWTON = 1'b0;
    localparam logic              METHOD_CFRAC  = 1'b1;
    localparam logic [ITER_W-1:0] ITER_RESET    = ITER_W'(32);

    typedef struct packed {
        logic                  start;
        logic [DIV_WIDTH-1:0]  dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DATA_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/isru_if.sv
// isru_x_if and isru_root_if: valid/ready channels carrying one operand word
// and one root word. depends on isru_pkg.

interface isru_x_if import isru_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface isru_root_if import isru_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] root_value;

    modport source (output valid, output root_value, input ready);
    modport sink   (input valid, input root_value, output ready);
endinterface

>>> sv/isru_div.sv
// isru_div: bit-serial restoring divider, one quotient bit per cycle,
// quotient saturated to the data width. depends on isru_pkg.

module isru_div import isru_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]  dq_reg, dq_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    assign trial = {rem_reg, dq_reg[DIV_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            dq_next  = {dq_reg[DIV_WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = (|dq_reg[DIV_WIDTH-1:DATA_WIDTH]) ? DATA_MAX
                                                            : dq_reg[DATA_WIDTH-1:0];

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg && cnt_reg == '0)
        else $error("divider did not restart its step count");
`endif

endmodule

>>> sv/iterative_square_root_unit_top.sv
// iterative_square_root_unit_top: square root of an unsigned Q16.16 word by
// Newton or continued-fraction iteration. depends on isru_pkg, isru_if, isru_div.

// One operand word is taken at a time. Each iteration runs one division through
// the shared bit-serial divider, which retires one quotient bit per cycle. An
// operand runs at most the iteration count in iterations for Newton and one
// less for continued fraction (a zero operand under Newton runs none). The result
// waits in an output register, so the next operand can be taken as soon as the
// previous root is held there. The user must write method and iteration_count
// only while the unit is idle; the block itself does not enforce this.

module iterative_square_root_unit_top import isru_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    isru_x_if.sink                operand,
    isru_root_if.source           result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic                  method_reg;
    logic [ITER_W-1:0]     iter_count_reg;

    logic [1:0]            state_reg, state_next;
    logic                  meth_reg, meth_next;
    logic [ITER_W-1:0]     iter_left_reg, iter_left_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] g_reg, g_next;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;

    logic [DATA_WIDTH:0]   den_sum;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH:0]   newton_sum;
    logic [DATA_WIDTH:0]   cf_sum;
    logic [DATA_WIDTH-1:0] cf_val;
    logic [DATA_WIDTH-1:0] step_val;
    logic                  in_acc;
    logic                  out_free;
    logic                  x_neg;
    logic [ITER_W-1:0]     iter_dec;

    div_req_t div_req;
    div_rsp_t div_rsp;

    isru_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg     <= METHOD_NEWTON;
            iter_count_reg <= ITER_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_METHOD:     method_reg     <= wr_data[0];
                REG_ITER_COUNT: iter_count_reg <= wr_data[ITER_W-1:0];
                default:        ;
            endcase
        end
    end

    assign den_sum    = {1'b0, ONE_FX} + {1'b0, g_reg};
    assign den        = den_sum[DATA_WIDTH] ? DATA_MAX : den_sum[DATA_WIDTH-1:0];
    assign newton_sum = {1'b0, g_reg} + {1'b0, div_rsp.quotient};
    assign cf_sum     = {1'b0, ONE_FX} + {1'b0, div_rsp.quotient};

    always_comb
    begin
        if (neg_reg)
            cf_val = (div_rsp.quotient > ONE_FX) ? '0 : ONE_FX - div_rsp.quotient;
        else
            cf_val = cf_sum[DATA_WIDTH] ? DATA_MAX : cf_sum[DATA_WIDTH-1:0];
    end

    assign step_val = (meth_reg == METHOD_NEWTON) ? newton_sum[DATA_WIDTH:1] : cf_val;
    assign in_acc   = operand.valid && operand.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign x_neg    = (operand.x_value < ONE_FX);
    assign iter_dec = iter_left_reg - 1'b1;

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = (meth_reg == METHOD_NEWTON)
                              ? {x_reg, {FRAC_BITS{1'b0}}}
                              : {mag_reg, {FRAC_BITS{1'b0}}};
    assign div_req.divisor  = (meth_reg == METHOD_NEWTON) ? g_reg : den;

    always_comb
    begin
        state_next     = state_reg;
        meth_next      = meth_reg;
        iter_left_next = iter_left_reg;
        x_next         = x_reg;
        g_next         = g_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    meth_next = method_reg;
                    x_next    = operand.x_value;
                    g_next    = operand.x_value;
                    neg_next  = x_neg;
                    mag_next  = x_neg ? ONE_FX - operand.x_value
                                      : operand.x_value - ONE_FX;
                    if (method_reg == METHOD_NEWTON)
                    begin
                        iter_left_next = iter_count_reg;
                        if (iter_count_reg == '0 || operand.x_value == '0)
                            state_next = ST_DONE;
                        else
                            state_next = ST_START;
                    end
                    else
                    begin
                        iter_left_next = (iter_count_reg == '0) ? '0
                                                                : iter_count_reg - 1'b1;
                        if (iter_count_reg <= ITER_W'(1))
                            state_next = ST_DONE;
                        else
                            state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    g_next         = step_val;
                    iter_left_next = iter_dec;
                    if (iter_dec == '0 || step_val == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_START;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = g_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meth_reg      <= meth_next;
        iter_left_reg <= iter_left_next;
        x_reg         <= x_next;
        g_reg         <= g_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        out_data_reg  <= out_data_next;
    end

    assign operand.ready     = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.root_value = out_data_reg;

`ifndef ASSERT_OFF
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy && !div_rsp.done)
        else $error("division started while divider in use");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_WAIT)
        else $error("quotient returned outside the wait state");

    a_start_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START |-> iter_left_reg != '0 && div_req.divisor != '0)
        else $error("iteration started with nothing left or a zero divisor");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_START || state_reg == ST_DONE)
        else $error("accepted word did not start work");
`endif

endmodule
